// ===== rtl/rldc_pkg.sv =====
// Shared constants and types for the raster line draw / obstacle check block.
// No dependencies; rldc_if, rldc_ds, the top level and the bench refer into it by scoped names.
package rldc_pkg;

    // Field widths on the channels
    localparam int OP_W       = 2;
    localparam int COORD_W    = 9;
    localparam int PIX_W      = 8;
    localparam int RW_W       = 10;
    localparam int THR_W      = 8;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 10;

    // Default geometry and fixed-point format
    localparam int MAX_WIDTH  = 512;
    localparam int MAX_HEIGHT = 512;
    localparam int FRAC_BITS  = 16;

    // Walk limit in visited pixels
    localparam int WALK_CAP = 4096;
    localparam int CNT_W    = 12;

    // Pixel coordinate, row*width+column sum, sqrt radicand, divider numerator
    localparam int PCRD_W = 10;
    localparam int VSUM_W = 21;
    localparam int RAD_W  = 20;
    localparam int NUM_W  = 9;

    localparam logic [RW_W-1:0]  RESET_RASTER_WIDTH = 10'd512;
    localparam logic [THR_W-1:0] RESET_THRESHOLD    = 8'd128;

    localparam logic [CFG_IDX_W-1:0] CFG_RASTER_WIDTH = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD    = 1'b1;

    typedef enum logic [OP_W-1:0] {
        OP_WRITE = 2'd0,
        OP_READ  = 2'd1,
        OP_DRAW  = 2'd2,
        OP_CHECK = 2'd3
    } t_op;

    typedef enum logic {
        DS_SQRT = 1'b0,
        DS_DIV  = 1'b1
    } t_ds_mode;

    typedef struct packed {
        logic     start;
        t_ds_mode mode;
    } t_ds_ctrl;

endpackage

// ===== rtl/rldc_if.sv =====
// Valid/ready channel interfaces: command items, results and register writes.
// Depends on rldc_pkg for field widths.
interface rldc_item_if;
    logic                           valid;
    logic                           ready;
    logic [rldc_pkg::OP_W-1:0]      operation;
    logic [rldc_pkg::COORD_W-1:0]   x_start;
    logic [rldc_pkg::COORD_W-1:0]   y_start;
    logic [rldc_pkg::COORD_W-1:0]   x_end;
    logic [rldc_pkg::COORD_W-1:0]   y_end;
    logic [rldc_pkg::PIX_W-1:0]     pixel_value;

    modport source (output valid, operation, x_start, y_start, x_end, y_end, pixel_value,
                    input ready);
    modport sink   (input valid, operation, x_start, y_start, x_end, y_end, pixel_value,
                    output ready);
endinterface

interface rldc_result_if;
    logic                           valid;
    logic                           ready;
    logic                           obstacle_found;
    logic [rldc_pkg::PIX_W-1:0]     read_value;

    modport source (output valid, obstacle_found, read_value, input ready);
    modport sink   (input valid, obstacle_found, read_value, output ready);
endinterface

interface rldc_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [rldc_pkg::CFG_IDX_W-1:0]   index;
    logic [rldc_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/rldc_mul.sv =====
// Shared unsigned multiplier with a registered product.
// Depends on nothing beyond its width parameter.
module rldc_mul #(
    parameter int W = 26
) (
    input  logic           i_clk,
    input  logic [W-1:0]   i_a,
    input  logic [W-1:0]   i_b,
    output logic [2*W-1:0] o_product
);

    logic [2*W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    assign o_product = r_prod;

endmodule

// ===== rtl/rldc_ds.sv =====
// Restoring square root / divider, one result bit per cycle on one subtractor.
// Depends on rldc_pkg (control struct, operand widths).
module rldc_ds #(
    parameter int FRAC_BITS = rldc_pkg::FRAC_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  rldc_pkg::t_ds_ctrl           i_ctrl,
    input  logic [rldc_pkg::RAD_W-1:0]   i_radicand,
    input  logic [rldc_pkg::NUM_W-1:0]   i_num,
    input  logic [FRAC_BITS+9:0]         i_den,
    output logic                         o_busy,
    output logic                         o_done,
    output logic [2*FRAC_BITS+8:0]       o_result
);

    localparam int ACC_W     = 2 * FRAC_BITS + 9;
    localparam int REM_W     = FRAC_BITS + 13;
    localparam int LEN_W     = FRAC_BITS + 10;
    localparam int RAD_W     = rldc_pkg::RAD_W;
    localparam int NUM_W     = rldc_pkg::NUM_W;
    localparam int SQ_STEPS  = FRAC_BITS + 10;
    localparam int DIV_STEPS = ACC_W;
    localparam int CNT_W     = $clog2(ACC_W + 1);

    logic                 r_busy;
    logic                 r_done;
    rldc_pkg::t_ds_mode   r_mode;
    logic [CNT_W-1:0]     r_cnt;
    logic [REM_W-1:0]     r_rem;
    logic [ACC_W-1:0]     r_acc;
    logic [ACC_W-1:0]     r_src;

    logic [REM_W-1:0]     rs;
    logic [REM_W-1:0]     trial;
    logic                 ge;
    logic                 last;

    always_comb begin
        if (r_mode == rldc_pkg::DS_SQRT) begin
            rs    = {r_rem[REM_W-3:0], r_src[ACC_W-1 -: 2]};
            trial = REM_W'({r_acc[LEN_W-1:0], 2'b01});
            last  = (r_cnt == CNT_W'(SQ_STEPS - 1));
        end else begin
            rs    = {r_rem[REM_W-2:0], r_src[ACC_W-1]};
            trial = REM_W'(i_den);
            last  = (r_cnt == CNT_W'(DIV_STEPS - 1));
        end
        ge = (rs >= trial);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_ctrl.start) begin
                r_busy <= 1'b1;
                r_mode <= i_ctrl.mode;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_acc  <= '0;
                if (i_ctrl.mode == rldc_pkg::DS_SQRT) begin
                    // radicand pairs feed from the top; zeros follow for the fraction
                    r_src <= {i_radicand, {(ACC_W-RAD_W){1'b0}}};
                end else begin
                    r_src <= {i_num, {(ACC_W-NUM_W){1'b0}}};
                end
            end else if (r_busy) begin
                r_rem <= ge ? (rs - trial) : rs;
                r_acc <= {r_acc[ACC_W-2:0], ge};
                r_src <= (r_mode == rldc_pkg::DS_SQRT) ? (r_src << 2) : (r_src << 1);
                r_cnt <= r_cnt + 1'b1;
                if (last) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_busy   = r_busy;
    assign o_done   = r_done;
    assign o_result = r_acc;

endmodule

// ===== rtl/raster_line_draw_and_obstacle_check.sv =====
// Top level: command sequencer, raster memory and register file.
// Depends on rldc_pkg, rldc_if, rldc_mul and rldc_ds.
//
// Holds a MAX_WIDTH*MAX_HEIGHT raster of 8-bit grey pixels and handles one
// command at a time. All addressing goes through the single shared multiplier
// (row*width, then a reciprocal multiply and back-multiply to wrap the address
// to the raster depth). A line command first does its setup (two squares, a
// bit-serial square root and two bit-serial divisions), then walks the line
// pixel by pixel; each visited pixel needs five products from the one
// multiplier. Pixels are not cleared at reset and read back undefined until
// written. A result may wait in the output register while the next command
// is taken.
module raster_line_draw_and_obstacle_check #(
    parameter int MAX_WIDTH  = rldc_pkg::MAX_WIDTH,
    parameter int MAX_HEIGHT = rldc_pkg::MAX_HEIGHT,
    parameter int FRAC_BITS  = rldc_pkg::FRAC_BITS
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    rldc_cfg_if.sink        i_cfg,
    rldc_item_if.sink       i_item,
    rldc_result_if.source   o_result
);

    localparam int DEPTH   = MAX_WIDTH * MAX_HEIGHT;
    localparam int AB      = $clog2(DEPTH);
    localparam int E_W     = FRAC_BITS + 10;
    localparam int POS_W   = FRAC_BITS + 11;
    localparam int DS_W    = 2 * E_W + 1;
    localparam int STEP_W  = FRAC_BITS + 3;
    localparam int LEN_W   = FRAC_BITS + 10;
    localparam int ACC_W   = 2 * FRAC_BITS + 9;
    localparam int V_W     = rldc_pkg::VSUM_W;
    localparam int K       = V_W + AB;
    localparam int R_W     = V_W + 2;
    localparam int MUL_W0  = (E_W > R_W) ? E_W : R_W;
    localparam int MUL_W   = (MUL_W0 > AB + 1) ? MUL_W0 : AB + 1;
    localparam int P_W     = 2 * MUL_W;
    localparam int PCRD_W  = rldc_pkg::PCRD_W;
    localparam int COORD_W = rldc_pkg::COORD_W;
    localparam int PIX_W   = rldc_pkg::PIX_W;
    localparam int RAD_W   = rldc_pkg::RAD_W;
    localparam int NUM_W   = rldc_pkg::NUM_W;
    localparam int CNT_W   = rldc_pkg::CNT_W;
    localparam logic [R_W-1:0] RECIP =
        R_W'(((64'd1 << K) + 64'(DEPTH) - 64'd1) / 64'(DEPTH));

    typedef enum logic [4:0] {
        S_IDLE, S_DX2, S_DY2, S_SQ, S_SQW, S_DX, S_DXW, S_DY, S_DYW,
        S_E1, S_E2, S_CMP, S_A1, S_A2, S_A3, S_A4, S_A5, S_DONE
    } t_state;

    t_state                         r_state;
    rldc_pkg::t_op                  r_op;
    logic [COORD_W-1:0]             r_xs, r_ys, r_xe, r_ye;
    logic [PIX_W-1:0]               r_val;
    logic [rldc_pkg::RW_W-1:0]      r_width;
    logic [rldc_pkg::THR_W-1:0]     r_thr;
    logic signed [COORD_W:0]        r_dx, r_dy;
    logic [LEN_W-1:0]               r_len;
    logic signed [STEP_W-1:0]       r_sx, r_sy;
    logic signed [POS_W-1:0]        r_x, r_y;
    logic [DS_W-1:0]                r_dsq, r_dprev;
    logic                           r_init;
    logic [CNT_W-1:0]               r_cnt;
    logic [PCRD_W-1:0]              r_col;
    logic [V_W-1:0]                 r_v;
    logic [PIX_W-1:0]               r_rd;
    logic                           r_pobst;
    logic [PIX_W-1:0]               r_pval;
    logic                           r_out_valid;
    logic                           r_obst;
    logic [PIX_W-1:0]               r_rdval;
    logic [PIX_W-1:0]               r_mem [DEPTH];

    logic [MUL_W-1:0]               m_a, m_b;
    logic [P_W-1:0]                 m_p;
    rldc_pkg::t_ds_ctrl             ds_ctrl;
    logic                           ds_busy, ds_done;
    logic [ACC_W-1:0]               ds_result;
    logic [RAD_W-1:0]               ds_rad;
    logic [NUM_W-1:0]               ds_num;

    logic [NUM_W-1:0]               dx_mag, dy_mag;
    logic signed [POS_W-1:0]        gx, gy, ex, ey;
    logic [E_W-1:0]                 ex_mag, ey_mag;
    logic [PCRD_W-1:0]              px_col, px_row, a_col, a_row;
    logic [DS_W-1:0]                dnew;
    logic [V_W-1:0]                 v_sum, q_est;
    logic [AB-1:0]                  addr;
    logic                           mem_we;
    logic                           is_line;
    logic signed [STEP_W-1:0]       q_step;
    logic                           out_free;

    rldc_mul #(.W(MUL_W)) u_mul (
        .i_clk     (i_clk),
        .i_a       (m_a),
        .i_b       (m_b),
        .o_product (m_p)
    );

    rldc_ds #(.FRAC_BITS(FRAC_BITS)) u_ds (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctrl     (ds_ctrl),
        .i_radicand (ds_rad),
        .i_num      (ds_num),
        .i_den      (r_len),
        .o_busy     (ds_busy),
        .o_done     (ds_done),
        .o_result   (ds_result)
    );

    always_comb begin
        dx_mag  = r_dx[COORD_W] ? NUM_W'(-r_dx) : NUM_W'(r_dx);
        dy_mag  = r_dy[COORD_W] ? NUM_W'(-r_dy) : NUM_W'(r_dy);
        gx      = $signed({{(POS_W-COORD_W-FRAC_BITS){1'b0}}, r_xe, {FRAC_BITS{1'b0}}});
        gy      = $signed({{(POS_W-COORD_W-FRAC_BITS){1'b0}}, r_ye, {FRAC_BITS{1'b0}}});
        ex      = gx - r_x;
        ey      = gy - r_y;
        ex_mag  = ex[POS_W-1] ? E_W'(-ex) : E_W'(ex);
        ey_mag  = ey[POS_W-1] ? E_W'(-ey) : E_W'(ey);
        // a walk never gets below -1, so truncation toward zero gives 0 there
        px_col  = r_x[POS_W-1] ? '0 : r_x[FRAC_BITS +: PCRD_W];
        px_row  = r_y[POS_W-1] ? '0 : r_y[FRAC_BITS +: PCRD_W];
        is_line = (r_op == rldc_pkg::OP_DRAW) || (r_op == rldc_pkg::OP_CHECK);
        a_col   = is_line ? px_col : PCRD_W'(r_xs);
        a_row   = is_line ? px_row : PCRD_W'(r_ys);
        dnew    = r_dsq + DS_W'(m_p[2*E_W-1:0]);
        v_sum   = V_W'(m_p[2*PCRD_W-1:0]) + V_W'(r_col);
        q_est   = V_W'(m_p >> K);
        addr    = AB'(r_v - V_W'(m_p));
        mem_we  = (r_state == S_A4) &&
                  ((r_op == rldc_pkg::OP_WRITE) || (r_op == rldc_pkg::OP_DRAW));
        ds_rad  = RAD_W'(r_dsq) + RAD_W'(m_p);
        ds_num  = (r_state == S_DX) ? dx_mag : dy_mag;
        q_step  = $signed({1'b0, ds_result[STEP_W-2:0]});
        out_free = !r_out_valid || o_result.ready;

        ds_ctrl.start = (r_state == S_SQ) || (r_state == S_DX) || (r_state == S_DY);
        ds_ctrl.mode  = (r_state == S_SQ) ? rldc_pkg::DS_SQRT : rldc_pkg::DS_DIV;
    end

    // multiplier operand routing
    always_comb begin
        m_a = '0;
        m_b = '0;
        unique case (r_state)
            S_DX2: begin
                m_a = MUL_W'(dx_mag);
                m_b = MUL_W'(dx_mag);
            end
            S_DY2: begin
                m_a = MUL_W'(dy_mag);
                m_b = MUL_W'(dy_mag);
            end
            S_E1: begin
                m_a = MUL_W'(ex_mag);
                m_b = MUL_W'(ex_mag);
            end
            S_E2: begin
                m_a = MUL_W'(ey_mag);
                m_b = MUL_W'(ey_mag);
            end
            S_A1: begin
                m_a = MUL_W'(a_row);
                m_b = MUL_W'(r_width);
            end
            S_A2: begin
                m_a = MUL_W'(v_sum);
                m_b = MUL_W'(RECIP);
            end
            S_A3: begin
                m_a = MUL_W'(q_est);
                m_b = MUL_W'(DEPTH);
            end
            default: begin
                m_a = '0;
                m_b = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[addr] <= r_val;
        end
        r_rd <= r_mem[addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_width     <= rldc_pkg::RESET_RASTER_WIDTH;
            r_thr       <= rldc_pkg::RESET_THRESHOLD;
            r_out_valid <= 1'b0;
            r_init      <= 1'b0;
            r_cnt       <= '0;
        end else begin
            if (i_cfg.valid) begin
                unique case (i_cfg.index)
                    rldc_pkg::CFG_RASTER_WIDTH: r_width <= i_cfg.data;
                    rldc_pkg::CFG_THRESHOLD:    r_thr   <= i_cfg.data[rldc_pkg::THR_W-1:0];
                    default: ;
                endcase
            end

            // a new result loaded in S_DONE takes precedence over the drain
            if (o_result.ready && !((r_state == S_DONE) && out_free)) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_item.valid) begin
                        r_op    <= rldc_pkg::t_op'(i_item.operation);
                        r_xs    <= i_item.x_start;
                        r_ys    <= i_item.y_start;
                        r_xe    <= i_item.x_end;
                        r_ye    <= i_item.y_end;
                        r_val   <= i_item.pixel_value;
                        r_dx    <= $signed({1'b0, i_item.x_end}) - $signed({1'b0, i_item.x_start});
                        r_dy    <= $signed({1'b0, i_item.y_end}) - $signed({1'b0, i_item.y_start});
                        r_pobst <= 1'b0;
                        r_pval  <= '0;
                        unique case (rldc_pkg::t_op'(i_item.operation)) inside
                            rldc_pkg::OP_DRAW, rldc_pkg::OP_CHECK: r_state <= S_DX2;
                            default:                               r_state <= S_A1;
                        endcase
                    end
                end
                S_DX2: r_state <= S_DY2;
                S_DY2: begin
                    r_dsq   <= DS_W'(m_p);
                    r_state <= S_SQ;
                end
                S_SQ: r_state <= S_SQW;
                S_SQW: begin
                    if (ds_done) begin
                        r_len   <= ds_result[LEN_W-1:0];
                        r_state <= S_DX;
                    end
                end
                S_DX: r_state <= S_DXW;
                S_DXW: begin
                    if (ds_done) begin
                        if (r_len == '0) begin
                            r_sx <= '0;
                        end else begin
                            r_sx <= r_dx[COORD_W] ? -q_step : q_step;
                        end
                        r_state <= S_DY;
                    end
                end
                S_DY: r_state <= S_DYW;
                S_DYW: begin
                    if (ds_done) begin
                        if (r_len == '0) begin
                            r_sy <= '0;
                        end else begin
                            r_sy <= r_dy[COORD_W] ? -q_step : q_step;
                        end
                        r_x     <= $signed({{(POS_W-COORD_W-FRAC_BITS){1'b0}}, r_xs,
                                            {FRAC_BITS{1'b0}}});
                        r_y     <= $signed({{(POS_W-COORD_W-FRAC_BITS){1'b0}}, r_ys,
                                            {FRAC_BITS{1'b0}}});
                        r_init  <= 1'b1;
                        r_state <= S_E1;
                    end
                end
                S_E1: r_state <= S_E2;
                S_E2: begin
                    r_dsq   <= DS_W'(m_p[2*E_W-1:0]);
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    // walk on while the goal distance shrinks, up to WALK_CAP
                    if (r_init) begin
                        r_dprev <= dnew;
                        r_init  <= 1'b0;
                        r_cnt   <= '0;
                        r_state <= S_A1;
                    end else if ((dnew < r_dprev) &&
                                 (r_cnt != CNT_W'(rldc_pkg::WALK_CAP - 1))) begin
                        r_dprev <= dnew;
                        r_cnt   <= r_cnt + 1'b1;
                        r_state <= S_A1;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_A1: begin
                    r_col   <= a_col;
                    r_state <= S_A2;
                end
                S_A2: begin
                    r_v     <= v_sum;
                    r_state <= S_A3;
                end
                S_A3: r_state <= S_A4;
                S_A4: begin
                    r_x <= r_x + POS_W'(r_sx);
                    r_y <= r_y + POS_W'(r_sy);
                    unique case (r_op)
                        rldc_pkg::OP_WRITE: r_state <= S_DONE;
                        rldc_pkg::OP_DRAW:  r_state <= S_E1;
                        default:            r_state <= S_A5;
                    endcase
                end
                S_A5: begin
                    if (r_op == rldc_pkg::OP_READ) begin
                        r_pval  <= r_rd;
                        r_state <= S_DONE;
                    end else if (r_rd < r_thr) begin
                        r_pobst <= 1'b1;
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_E1;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_obst      <= r_pobst;
                        r_rdval     <= r_pval;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign i_cfg.ready             = 1'b1;
    assign i_item.ready            = (r_state == S_IDLE);
    assign o_result.valid          = r_out_valid;
    assign o_result.obstacle_found = r_obst;
    assign o_result.read_value     = r_rdval;

    a_ds_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ds_ctrl.start |-> !ds_busy)
        else $error("root/divide unit restarted while busy");

    a_read_follows_access: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_A5) |-> ($past(r_state) == S_A4))
        else $error("pixel compare without a memory access before it");

    a_result_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid |-> !(o_result.obstacle_found && (o_result.read_value != '0)))
        else $error("result carries both an obstacle flag and a read value");

endmodule

// ===== sim/tb_top.sv =====
// Testbench for raster_line_draw_and_obstacle_check: directed and random commands,
// self-checking against an in-bench raster predictor. Needs rldc_pkg, rldc_if and the RTL.
module tb_top;

    localparam int  COORD_W    = rldc_pkg::COORD_W;
    localparam int  PIX_W      = rldc_pkg::PIX_W;
    localparam int  FRAC_BITS  = rldc_pkg::FRAC_BITS;
    localparam int  WALK_CAP   = rldc_pkg::WALK_CAP;
    localparam int  CFG_IDX_W  = rldc_pkg::CFG_IDX_W;
    localparam int  CFG_DATA_W = rldc_pkg::CFG_DATA_W;
    localparam int  DEPTH      = rldc_pkg::MAX_WIDTH * rldc_pkg::MAX_HEIGHT;
    localparam int  CYC_LIMIT  = 20000000;
    localparam int  WALK_ERR   = 2;

    typedef struct packed {
        rldc_pkg::t_op      op;
        logic [COORD_W-1:0] xs;
        logic [COORD_W-1:0] ys;
        logic [COORD_W-1:0] xe;
        logic [COORD_W-1:0] ye;
        logic [PIX_W-1:0]   pv;
    } t_cmd;

    typedef struct packed {
        logic             obstacle;
        logic [PIX_W-1:0] value;
    } t_res;

    logic i_clk;
    logic i_rst_n;

    rldc_item_if   itm();
    rldc_result_if res();
    rldc_cfg_if    cfg();

    raster_line_draw_and_obstacle_check dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_item   (itm),
        .o_result (res)
    );

    // raster shadow
    logic [PIX_W-1:0] shadow_pix [DEPTH];
    bit               shadow_wr  [DEPTH];
    int unsigned      cur_width;
    int unsigned      cur_thr;

    t_cmd  cmd_q[$];
    t_res  result_q[$];
    t_cmd  drawn_lines[$];
    t_cmd  written_px[$];
    int    errors = 0;
    bit    quiet;
    int    cyc = 0;

    function automatic longint unsigned root_q16(longint unsigned v);
        longint unsigned rem, root, bits, trial;
        rem = 0;
        root = 0;
        for (int p = 10 + FRAC_BITS - 1; p >= 0; p--) begin
            bits = (p >= FRAC_BITS) ? ((v >> (2 * (p - FRAC_BITS))) & 3) : 0;
            rem = (rem << 2) | bits;
            trial = (root << 2) | 1;
            if (rem >= trial) begin
                rem -= trial;
                root = (root << 1) | 1;
            end else begin
                root = root << 1;
            end
        end
        return root;
    endfunction

    function automatic longint unit_step(longint delta, longint unsigned len);
        longint unsigned q, m;
        if (len == 0)
            return 0;
        m = (delta < 0) ? -delta : delta;
        q = (m << (2 * FRAC_BITS)) / len;
        return (delta < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic longint to_pixel(longint p);
        return (p >= 0) ? (p >>> FRAC_BITS) : -((-p) >>> FRAC_BITS);
    endfunction

    function automatic int pixel_addr(longint col, longint row);
        longint a;
        a = row * longint'(cur_width) + col;
        a = a % DEPTH;
        if (a < 0)
            a += DEPTH;
        return int'(a);
    endfunction

    function automatic logic [127:0] dist_sq(longint ex, longint ey);
        logic [127:0] a, b;
        a = 128'((ex < 0) ? -ex : ex);
        b = 128'((ey < 0) ? -ey : ey);
        return a * a + b * b;
    endfunction

    // Draw (chk=0) or check a line; check returns 1 on obstacle, WALK_ERR if it
    // would touch an unwritten pixel (so the command is dropped).
    function automatic int walk_line(t_cmd c, bit chk);
        longint dx, dy, sx, sy, x, y, gx, gy;
        logic [127:0] d_prev, d_next;
        int a;
        dx = longint'(c.xe) - longint'(c.xs);
        dy = longint'(c.ye) - longint'(c.ys);
        sx = unit_step(dx, root_q16(dx * dx + dy * dy));
        sy = unit_step(dy, root_q16(dx * dx + dy * dy));
        x  = longint'(c.xs) <<< FRAC_BITS;
        y  = longint'(c.ys) <<< FRAC_BITS;
        gx = longint'(c.xe) <<< FRAC_BITS;
        gy = longint'(c.ye) <<< FRAC_BITS;
        d_next = dist_sq(gx - x, gy - y);
        for (int n = 0; n < WALK_CAP; n++) begin
            a = pixel_addr(to_pixel(x), to_pixel(y));
            d_prev = d_next;
            if (chk) begin
                if (!shadow_wr[a])
                    return WALK_ERR;
                if (shadow_pix[a] < cur_thr)
                    return 1;
            end else begin
                shadow_pix[a] = c.pv;
                shadow_wr[a] = 1'b1;
            end
            x += sx;
            y += sy;
            d_next = dist_sq(gx - x, gy - y);
            if (!(d_next < d_prev))
                break;
        end
        return 0;
    endfunction

    // Predicts a command and queues it; returns 0 if it would read unwritten pixels.
    function automatic bit issue_cmd(t_cmd c);
        t_res r;
        int   a, w;
        r = '0;
        a = pixel_addr(c.xs, c.ys);
        case (c.op)
            rldc_pkg::OP_WRITE: begin
                shadow_pix[a] = c.pv;
                shadow_wr[a] = 1'b1;
                written_px.push_back(c);
            end
            rldc_pkg::OP_READ: begin
                if (!shadow_wr[a])
                    return 0;
                r.value = shadow_pix[a];
            end
            rldc_pkg::OP_DRAW: begin
                void'(walk_line(c, 1'b0));
                drawn_lines.push_back(c);
                if (drawn_lines.size() > 64)
                    void'(drawn_lines.pop_front());
            end
            default: begin
                w = walk_line(c, 1'b1);
                if (w == WALK_ERR)
                    return 0;
                r.obstacle = w[0];
            end
        endcase
        cmd_q.push_back(c);
        result_q.push_back(r);
        return 1;
    endfunction

    function automatic t_cmd rand_line(rldc_pkg::t_op op);
        t_cmd c;
        int   span;
        c.op = op;
        c.pv = PIX_W'($urandom);
        c.xs = COORD_W'($urandom);
        c.ys = COORD_W'($urandom);
        if ($urandom_range(0, 32) == 0) begin
            c.xe = COORD_W'($urandom);
            c.ye = COORD_W'($urandom);
        end else begin
            span = $urandom_range(0, 14);
            c.xe = COORD_W'(int'(c.xs) + int'($urandom_range(0, 2 * span)) - span);
            c.ye = COORD_W'(int'(c.ys) + int'($urandom_range(0, 2 * span)) - span);
        end
        return c;
    endfunction

    function automatic void rand_cmd();
        t_cmd c;
        int   sel;
        sel = $urandom_range(0, 99);
        if (sel < 30) begin
            c = rand_line(rldc_pkg::OP_WRITE);
            void'(issue_cmd(c));
            return;
        end
        if (sel < 45) begin
            for (int t = 0; t < 10; t++) begin
                c = rand_line(rldc_pkg::OP_READ);
                if (written_px.size() > 0 && $urandom_range(0, 3) != 0) begin
                    c.xs = written_px[$urandom_range(0, written_px.size() - 1)].xs;
                    c.ys = written_px[$urandom_range(0, written_px.size() - 1)].ys;
                    if ($urandom_range(0, 1))
                        c.ys = written_px[written_px.size() - 1].ys;
                end
                if (issue_cmd(c))
                    return;
            end
        end else if (sel >= 75) begin
            for (int t = 0; t < 10; t++) begin
                c = rand_line(rldc_pkg::OP_CHECK);
                if (drawn_lines.size() > 0 && $urandom_range(0, 4) != 0) begin
                    c = drawn_lines[$urandom_range(0, drawn_lines.size() - 1)];
                    c.op = rldc_pkg::OP_CHECK;
                    c.pv = PIX_W'($urandom);
                end
                if (issue_cmd(c))
                    return;
            end
        end
        void'(issue_cmd(rand_line(rldc_pkg::OP_DRAW)));
    endfunction

    function automatic t_cmd mk(rldc_pkg::t_op op, int xs, int ys, int xe, int ye, int pv);
        t_cmd c;
        c.op = op;
        c.xs = COORD_W'(xs);
        c.ys = COORD_W'(ys);
        c.xe = COORD_W'(xe);
        c.ye = COORD_W'(ye);
        c.pv = PIX_W'(pv);
        return c;
    endfunction

    task automatic wait_drained();
        while (cmd_q.size() != 0 || result_q.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, int unsigned val);
        @(posedge i_clk);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= CFG_DATA_W'(val);
        do
            @(posedge i_clk);
        while (!cfg.ready);
        cfg.valid <= 1'b0;
        if (idx == rldc_pkg::CFG_RASTER_WIDTH)
            cur_width = val;
        else
            cur_thr = val;
    endtask

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (cyc > CYC_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // command driver
    int idle_in = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            itm.valid <= 1'b0;
        end else begin
            if (itm.valid && itm.ready)
                void'(cmd_q.pop_front());
            if (!(itm.valid && !itm.ready)) begin
                if (idle_in > 0) begin
                    idle_in <= idle_in - 1;
                    itm.valid <= 1'b0;
                end else if (!quiet && $urandom_range(0, 9) == 0) begin
                    idle_in <= $urandom_range(0, 7);
                    itm.valid <= 1'b0;
                end else if (cmd_q.size() > 0) begin
                    itm.valid       <= 1'b1;
                    itm.operation   <= cmd_q[0].op;
                    itm.x_start     <= cmd_q[0].xs;
                    itm.y_start     <= cmd_q[0].ys;
                    itm.x_end       <= cmd_q[0].xe;
                    itm.y_end       <= cmd_q[0].ye;
                    itm.pixel_value <= cmd_q[0].pv;
                end else begin
                    itm.valid <= 1'b0;
                end
            end
        end
    end

    // result monitor with random back-pressure (off while quiet)
    int   idle_out = 0;
    t_res want;
    always @(posedge i_clk) begin
        if (i_rst_n && res.valid && res.ready) begin
            if (result_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result obstacle=%0d value=%0d", $time,
                         res.obstacle_found, res.read_value);
            end else begin
                want = result_q.pop_front();
                if (res.obstacle_found !== want.obstacle) begin
                    errors++;
                    $display("%0t: obstacle_found expected %0d actual %0d", $time,
                             want.obstacle, res.obstacle_found);
                end
                if (res.read_value !== want.value) begin
                    errors++;
                    $display("%0t: read_value expected %0d actual %0d", $time,
                             want.value, res.read_value);
                end
            end
        end
        if (idle_out > 0) begin
            idle_out <= idle_out - 1;
            res.ready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 9) == 0) begin
            idle_out <= $urandom_range(0, 7);
            res.ready <= 1'b0;
        end else begin
            res.ready <= 1'b1;
        end
    end

    initial begin
        int unsigned widths [6];
        int unsigned thrs   [6];
        quiet = 1'b0;
        cur_width = 32'(rldc_pkg::RESET_RASTER_WIDTH);
        cur_thr = 32'(rldc_pkg::RESET_THRESHOLD);
        i_rst_n <= 1'b0;
        cfg.valid <= 1'b0;
        cfg.index <= rldc_pkg::CFG_RASTER_WIDTH;
        cfg.data <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        widths = '{512, 1, 1023, 0, 257, 512};
        thrs   = '{128, 0, 255, 60, 200, 128};
        for (int ph = 0; ph < 6; ph++) begin
            wait_drained();
            cfg_write(rldc_pkg::CFG_RASTER_WIDTH, widths[ph]);
            cfg_write(rldc_pkg::CFG_THRESHOLD, ph == 4 ? $urandom_range(1, 254) : thrs[ph]);
            drawn_lines.delete();
            written_px.delete();
            quiet = (ph == 5);
            if (ph == 0) begin
                void'(issue_cmd(mk(rldc_pkg::OP_WRITE, 0, 0, 0, 0, 255)));
                void'(issue_cmd(mk(rldc_pkg::OP_WRITE, 511, 511, 511, 511, 0)));
                void'(issue_cmd(mk(rldc_pkg::OP_READ, 0, 0, 511, 511, 0)));
                void'(issue_cmd(mk(rldc_pkg::OP_READ, 511, 511, 0, 0, 255)));
                // zero-length line: only the start pixel
                void'(issue_cmd(mk(rldc_pkg::OP_DRAW, 5, 5, 5, 5, 7)));
                void'(issue_cmd(mk(rldc_pkg::OP_READ, 5, 5, 0, 0, 0)));
                void'(issue_cmd(mk(rldc_pkg::OP_CHECK, 5, 5, 5, 5, 0)));
                void'(issue_cmd(mk(rldc_pkg::OP_DRAW, 0, 0, 511, 511, 200)));
                void'(issue_cmd(mk(rldc_pkg::OP_CHECK, 0, 0, 511, 511, 0)));
                void'(issue_cmd(mk(rldc_pkg::OP_DRAW, 511, 0, 0, 511, 10)));
                void'(issue_cmd(mk(rldc_pkg::OP_CHECK, 0, 511, 511, 0, 0)));
                void'(issue_cmd(mk(rldc_pkg::OP_DRAW, 0, 300, 511, 300, 128)));
                void'(issue_cmd(mk(rldc_pkg::OP_CHECK, 511, 300, 0, 300, 0)));
                void'(issue_cmd(mk(rldc_pkg::OP_DRAW, 100, 0, 100, 511, 127)));
                void'(issue_cmd(mk(rldc_pkg::OP_CHECK, 100, 511, 100, 0, 0)));
                void'(issue_cmd(mk(rldc_pkg::OP_READ, 100, 300, 0, 0, 0)));
            end
            for (int i = 0; i < 125; i++)
                rand_cmd();
        end

        wait_drained();
        repeat (40) @(posedge i_clk);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/rldc_pkg.sv
rtl/rldc_if.sv
rtl/rldc_mul.sv
rtl/rldc_ds.sv
rtl/raster_line_draw_and_obstacle_check.sv
sim/tb_top.sv
